### rtl/ppfd_pkg.sv
package ppfd_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int COORD_BITS_DEF   = 32;
	localparam int MAX_STEPS        = 32;

	// vectoring residues: 33-bit difference times 2^20, plus headroom for cordic growth
	localparam int VW = 56;
	// rotation residues in q2.30 plus growth
	localparam int RW = 34;

	localparam logic [31:0] GAIN_Q30     = 32'd652032874;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [32:0] QUARTER_TURN = 33'sh0_4000_0000;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'd536870912;
			1: t = 32'd316933406;
			2: t = 32'd167458907;
			3: t = 32'd85004756;
			4: t = 32'd42667331;
			5: t = 32'd21354465;
			6: t = 32'd10679838;
			7: t = 32'd5340245;
			8: t = 32'd2670163;
			9: t = 32'd1335087;
			10: t = 32'd667544;
			11: t = 32'd333772;
			12: t = 32'd166886;
			13: t = 32'd83443;
			14: t = 32'd41722;
			15: t = 32'd20861;
			16: t = 32'd10430;
			17: t = 32'd5215;
			18: t = 32'd2608;
			19: t = 32'd1304;
			20: t = 32'd652;
			21: t = 32'd326;
			22: t = 32'd163;
			23: t = 32'd81;
			24: t = 32'd41;
			25: t = 32'd20;
			26: t = 32'd10;
			27: t = 32'd5;
			28: t = 32'd3;
			29: t = 32'd1;
			30: t = 32'd1;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

	// payload carried beside the cordic datapath
	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] offset;
		logic signed [31:0] reach;
		logic               undef;
	} side_t;

endpackage

### rtl/polar_point_from_direction_unit.sv
// throughput: one item per cycle while the output register is not stalled; set by one micro-rotation per pipeline stage
// in both the vectoring and rotation chains
// the whole pipeline advances together; it holds while the output register is full and not taken
// reset: arst_n clears all valid bits, payload registers are not reset
module polar_point_from_direction_unit #(
	parameter int CORDIC_STEPS = ppfd_pkg::CORDIC_STEPS_DEF,
	parameter int COORD_BITS   = ppfd_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] toward_x,
	input  logic signed [31:0] toward_y,
	input  logic signed [31:0] angle_offset,
	input  logic signed [31:0] reach,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic               direction_undefined
);
	localparam int RW = ppfd_pkg::RW;
	localparam int CB = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam logic signed [33:0] HI = 34'sd2 ** (CB - 1) - 34'sd1;
	localparam logic signed [33:0] LO = -HI - 34'sd1;

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: differences
	logic               vld_s1;
	logic signed [32:0] dx_s1, dy_s1;
	ppfd_pkg::side_t    sd_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(toward_x) - 33'(start_x);
			dy_s1 <= 33'(toward_y) - 33'(start_y);
			sd_s1.sx <= start_x;
			sd_s1.sy <= start_y;
			sd_s1.offset <= angle_offset;
			sd_s1.reach <= reach;
			sd_s1.undef <= (toward_x == start_x) && (toward_y == start_y);
		end
	end

	logic            vv;
	logic [31:0]     ang;
	ppfd_pkg::side_t vsd;
	ppfd_vector #(.STEPS(CORDIC_STEPS)) u_vec (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s1), .in_dx(dx_s1), .in_dy(dy_s1), .in_side(sd_s1),
		.out_valid(vv), .out_ang(ang), .out_side(vsd)
	);

	logic            rv, rflip;
	logic signed [RW-1:0] rsin, rcos;
	ppfd_pkg::side_t rsd;
	ppfd_rotate #(.STEPS(CORDIC_STEPS)) u_rot (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vv), .in_theta(ang + vsd.offset), .in_side(vsd),
		.out_valid(rv), .out_sin(rsin), .out_cos(rcos), .out_flip(rflip),
		.out_side(rsd)
	);

	// stage a: apply flip
	logic               vld_s2;
	logic signed [RW-1:0] s_s2, c_s2;
	ppfd_pkg::side_t    sd_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= rv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= rflip ? -rsin : rsin;
			c_s2 <= rflip ? -rcos : rcos;
			sd_s2 <= rsd;
		end
	end

	// stage b: products
	logic               vld_s3;
	logic signed [65:0] px_s3, py_s3;
	ppfd_pkg::side_t    sd_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= 66'(sd_s2.reach) * 66'(s_s2);
			py_s3 <= 66'(sd_s2.reach) * 66'(c_s2);
			sd_s3 <= sd_s2;
		end
	end

	// stage c: round, add start (start alone when the direction is undefined)
	logic               vld_s4;
	logic signed [33:0] sumx_s4, sumy_s4;
	logic               und_s4;
	logic signed [65:0] rx, ry;
	always_comb begin
		rx = px_s3 + 66'sd536870912;
		ry = py_s3 + 66'sd536870912;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			und_s4 <= sd_s3.undef;
			if (sd_s3.undef) begin
				sumx_s4 <= 34'(sd_s3.sx);
				sumy_s4 <= 34'(sd_s3.sy);
			end else begin
				sumx_s4 <= 34'(sd_s3.sx) + 34'(rx >>> 30);
				sumy_s4 <= 34'(sd_s3.sy) + 34'(ry >>> 30);
			end
		end
	end

	// output register: saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			point_x <= (sumx_s4 > HI) ? 32'(HI) : (sumx_s4 < LO) ? 32'(LO) : 32'(sumx_s4);
			point_y <= (sumy_s4 > HI) ? 32'(HI) : (sumy_s4 < LO) ? 32'(LO) : 32'(sumy_s4);
			direction_undefined <= und_s4;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready does not follow output register");
	a_undef: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && en && und_s4 |=> direction_undefined)
		else $error("undefined flag lost");
endmodule

### rtl/ppfd_vector.sv
// half-turn pre-rotation when dy is negative, then one vectoring micro-rotation per register stage, stalled as a whole
module ppfd_vector #(
	parameter int STEPS = ppfd_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [32:0]            in_dx,
	input  logic signed [32:0]            in_dy,
	input  ppfd_pkg::side_t               in_side,
	output logic                          out_valid,
	output logic [31:0]                   out_ang,
	output ppfd_pkg::side_t               out_side
);
	localparam int VW = ppfd_pkg::VW;
	localparam int N = (STEPS < ppfd_pkg::MAX_STEPS) ? STEPS : ppfd_pkg::MAX_STEPS;

	logic signed [VW-1:0] u_s1 [N+1];
	logic signed [VW-1:0] v_s1 [N+1];
	logic [31:0]          a_s1 [N+1];
	ppfd_pkg::side_t      sd_s1 [N+1];
	logic                 vld_s1 [N+1];

	logic signed [VW-1:0] u0, v0;
	always_comb begin
		u0 = VW'(in_dy) <<< 20;
		v0 = VW'(in_dx) <<< 20;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1[0] <= 1'b0;
		end else if (en) begin
			vld_s1[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (in_dy[32]) begin
				u_s1[0] <= -u0;
				v_s1[0] <= -v0;
				a_s1[0] <= ppfd_pkg::HALF_TURN;
			end else begin
				u_s1[0] <= u0;
				v_s1[0] <= v0;
				a_s1[0] <= '0;
			end
			sd_s1[0] <= in_side;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[i+1] <= 1'b0;
			end else if (en) begin
				vld_s1[i+1] <= vld_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!v_s1[i][VW-1]) begin
					u_s1[i+1] <= u_s1[i] + (v_s1[i] >>> i);
					v_s1[i+1] <= v_s1[i] - (u_s1[i] >>> i);
					a_s1[i+1] <= a_s1[i] + ppfd_pkg::atan_turn(i);
				end else begin
					u_s1[i+1] <= u_s1[i] - (v_s1[i] >>> i);
					v_s1[i+1] <= v_s1[i] + (u_s1[i] >>> i);
					a_s1[i+1] <= a_s1[i] - ppfd_pkg::atan_turn(i);
				end
				sd_s1[i+1] <= sd_s1[i];
			end
		end
	end

	assign out_valid = vld_s1[N];
	assign out_ang   = a_s1[N];
	assign out_side  = sd_s1[N];
endmodule

### rtl/ppfd_rotate.sv
// angle reduction, then one rotation micro-step per register stage
module ppfd_rotate #(
	parameter int STEPS = ppfd_pkg::CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [31:0]          in_theta,
	input  ppfd_pkg::side_t      in_side,
	output logic                 out_valid,
	output logic signed [ppfd_pkg::RW-1:0] out_sin,
	output logic signed [ppfd_pkg::RW-1:0] out_cos,
	output logic                 out_flip,
	output ppfd_pkg::side_t      out_side
);
	localparam int RW = ppfd_pkg::RW;
	localparam int N = (STEPS < ppfd_pkg::MAX_STEPS) ? STEPS : ppfd_pkg::MAX_STEPS;

	logic signed [RW-1:0] x_s1 [N+1];
	logic signed [RW-1:0] y_s1 [N+1];
	logic signed [32:0]   z_s1 [N+1];
	logic                 fl_s1 [N+1];
	ppfd_pkg::side_t      sd_s1 [N+1];
	logic                 vld_s1 [N+1];

	logic signed [32:0] zs;
	logic signed [32:0] zr;
	logic               fr;
	always_comb begin
		zs = {in_theta[31], in_theta};
		zr = zs;
		fr = 1'b0;
		if (zs > $signed(ppfd_pkg::QUARTER_TURN)) begin
			zr = zs - 33'sh0_8000_0000;
			fr = 1'b1;
		end else if (zs < -$signed(ppfd_pkg::QUARTER_TURN)) begin
			zr = zs + 33'sh0_8000_0000;
			fr = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1[0] <= 1'b0;
		end else if (en) begin
			vld_s1[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1[0]  <= RW'($signed({1'b0, ppfd_pkg::GAIN_Q30}));
			y_s1[0]  <= '0;
			z_s1[0]  <= zr;
			fl_s1[0] <= fr;
			sd_s1[0] <= in_side;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[i+1] <= 1'b0;
			end else if (en) begin
				vld_s1[i+1] <= vld_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s1[i][32]) begin
					x_s1[i+1] <= x_s1[i] - (y_s1[i] >>> i);
					y_s1[i+1] <= y_s1[i] + (x_s1[i] >>> i);
					z_s1[i+1] <= z_s1[i] - $signed({1'b0, ppfd_pkg::atan_turn(i)});
				end else begin
					x_s1[i+1] <= x_s1[i] + (y_s1[i] >>> i);
					y_s1[i+1] <= y_s1[i] - (x_s1[i] >>> i);
					z_s1[i+1] <= z_s1[i] + $signed({1'b0, ppfd_pkg::atan_turn(i)});
				end
				fl_s1[i+1] <= fl_s1[i];
				sd_s1[i+1] <= sd_s1[i];
			end
		end
	end

	assign out_valid = vld_s1[N];
	assign out_sin   = y_s1[N];
	assign out_cos   = x_s1[N];
	assign out_flip  = fl_s1[N];
	assign out_side  = sd_s1[N];
endmodule
